// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } response_t;

endpackage : lkvc_pkg
`default_nettype wire

// ===== sv/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request runs through the key scan, the last compare and the update before
// the done strobe; a new start may be taken in the cycle of done.
// A new request is not taken until the last one is done: the key scan reads the
// key memory one entry per cycle, then the last compare, the update and the idle
// cycle that holds done follow.
// The receiver cannot stall: done is high for a single cycle.
// Reset clears valid marks, age ranks and occupancy and sets capacity to 16;
// key and value memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             start,
    output logic                  busy,
    input  wire request_t         request,
    // result channel
    output logic                  done,
    output response_t             response,
    // capacity register
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    // Index, rank and occupancy widths follow from the depth.
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0] CAP_MAX     = CMP_W'(ENTRIES);
    localparam logic [CMP_W-1:0] CAP_MIN     = CMP_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,    // issue key/value reads, one entry per cycle
        ST_LAST,    // compare the final entry
        ST_UPDATE   // write back, reorder ranks, present the result
    } state_t;

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    state_t                  state_reg, state_next;
    request_t                req_reg;
    logic [CAP_W-1:0]        capacity_reg;
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic                    valid_reg [ENTRIES];
    logic [RANK_W-1:0]       rank_reg  [ENTRIES];

    // Key and value memories: one read and one write port each.
    logic [KEY_W-1:0]        key_mem   [ENTRIES];
    logic [VAL_W-1:0]        val_mem   [ENTRIES];

    // Scan pipeline: read address, then the compare stage on the registered read data.
    logic [IDX_W-1:0]        addr_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic [KEY_W-1:0]        key_rd_reg;
    logic [VAL_W-1:0]        val_rd_reg;

    // Scan results
    logic                    found_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [RANK_W-1:0]       hit_rank_reg;
    logic [VAL_W-1:0]        hit_val_reg;
    logic                    any_reg;
    logic [IDX_W-1:0]        best_reg;
    logic [RANK_W-1:0]       best_rank_reg;
    logic [KEY_W-1:0]        best_key_reg;
    logic                    free_any_reg;
    logic [IDX_W-1:0]        free_idx_reg;

    // Registered outputs
    logic                    done_reg;
    response_t               rsp_reg, rsp_next;

    // ------------------------------------------------------------------------
    // Compare stage decode
    // ------------------------------------------------------------------------
    logic                    ent_valid;
    logic [RANK_W-1:0]       ent_rank;
    logic                    ent_match;
    logic                    ent_older;

    assign ent_valid = valid_reg[cmp_idx_reg];
    assign ent_rank  = rank_reg[cmp_idx_reg];
    assign ent_match = ent_valid && (key_rd_reg == req_reg.key);
    assign ent_older = ent_valid && (!any_reg || (ent_rank > best_rank_reg));

    // ------------------------------------------------------------------------
    // Update decisions
    // ------------------------------------------------------------------------
    logic [CMP_W-1:0]        cap_eff;
    logic                    is_put;
    logic                    do_touch;
    logic                    do_ev;
    logic                    do_ins;
    logic [IDX_W-1:0]        ins_slot;
    logic                    key_we;
    logic                    val_we;
    logic [IDX_W-1:0]        val_waddr;

    always_comb
    begin
        // zero means one, anything above the depth saturates
        cap_eff = CMP_W'(capacity_reg);
        if (cap_eff == '0)
            cap_eff = CAP_MIN;
        else if (cap_eff > CAP_MAX)
            cap_eff = CAP_MAX;

        is_put   = (req_reg.kind == KIND_PUT);
        do_touch = found_reg;
        do_ev    = !found_reg && is_put && any_reg && (CMP_W'(occ_reg) >= cap_eff);
        do_ins   = !found_reg && is_put && (free_any_reg || do_ev);

        // lowest free slot once the victim has been dropped
        if (do_ev && !(free_any_reg && (free_idx_reg < best_reg)))
            ins_slot = best_reg;
        else
            ins_slot = free_idx_reg;

        key_we    = (state_reg == ST_UPDATE) && do_ins;
        val_we    = (state_reg == ST_UPDATE) && is_put && (found_reg || do_ins);
        val_waddr = found_reg ? slot_reg : ins_slot;

        occ_next = occ_reg;
        if (do_ev && !do_ins)
            occ_next = occ_reg - OCC_W'(1);
        else if (do_ins && !do_ev)
            occ_next = occ_reg + OCC_W'(1);

        rsp_next             = '0;
        rsp_next.hit         = found_reg;
        rsp_next.read_value  = (found_reg && !is_put) ? hit_val_reg : '0;
        rsp_next.evicted     = do_ev;
        rsp_next.evicted_key = do_ev ? best_key_reg : '0;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control state and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            occ_reg      <= '0;
            done_reg     <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            addr_reg     <= '0;
            found_reg    <= 1'b0;
            any_reg      <= 1'b0;
            free_any_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (cfg_we)
                capacity_reg <= cfg_wdata;

            // compare stage sees each read address in the next cycle
            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= addr_reg;

            if (state_reg == ST_IDLE && start)
            begin
                req_reg      <= request;
                addr_reg     <= '0;
                found_reg    <= 1'b0;
                any_reg      <= 1'b0;
                free_any_reg <= 1'b0;
            end

            if (state_reg == ST_SCAN && addr_reg != LAST_IDX)
                addr_reg <= addr_reg + IDX_W'(1);

            if (cmp_vld_reg)
            begin
                // first matching entry wins
                if (ent_match && !found_reg)
                begin
                    found_reg    <= 1'b1;
                    slot_reg     <= cmp_idx_reg;
                    hit_rank_reg <= ent_rank;
                    hit_val_reg  <= val_rd_reg;
                end
                if (ent_older)
                begin
                    any_reg       <= 1'b1;
                    best_reg      <= cmp_idx_reg;
                    best_rank_reg <= ent_rank;
                    best_key_reg  <= key_rd_reg;
                end
                if (!ent_valid && !free_any_reg)
                begin
                    free_any_reg <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end

            if (state_reg == ST_UPDATE)
            begin
                occ_reg  <= occ_next;
                done_reg <= 1'b1;
                rsp_reg  <= rsp_next;

                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (do_touch)
                    begin
                        // hit: entry goes to the front, newer ones age by one
                        if (IDX_W'(i) == slot_reg)
                            rank_reg[i] <= '0;
                        else if (valid_reg[i] && rank_reg[i] < hit_rank_reg)
                            rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                    else if (do_ins && IDX_W'(i) == ins_slot)
                    begin
                        valid_reg[i] <= 1'b1;
                        rank_reg[i]  <= '0;
                    end
                    else if (do_ev && IDX_W'(i) == best_reg)
                    begin
                        valid_reg[i] <= 1'b0;
                        rank_reg[i]  <= '0;
                    end
                    else if (do_ins && valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Key and value memories
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            key_rd_reg <= key_mem[addr_reg];
            val_rd_reg <= val_mem[addr_reg];
        end
        if (key_we)
            key_mem[ins_slot] <= req_reg.key;
        if (val_we)
            val_mem[val_waddr] <= req_reg.value;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule : lru_key_value_cache_unit
`default_nettype wire
